/* rtl/mexp_pkg.sv */
// Shared types, constants and modular add helper for the modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int BIT_W      = $clog2(WORD_WIDTH);
   localparam int CSR_IDX_W  = 2;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [BIT_W-1:0]      bit_idx_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   localparam bit_idx_type BIT_LAST = bit_idx_type'(WORD_WIDTH - 1);

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam csr_idx_type REG_MODULUS     = csr_idx_type'(0);
   localparam csr_idx_type REG_PUBLIC_EXP  = csr_idx_type'(1);
   localparam csr_idx_type REG_PRIVATE_EXP = csr_idx_type'(2);

   // launch of one modular multiply: product = a * b mod modulus, a below modulus
   typedef struct packed {
      logic     start;
      word_type a;
      word_type b;
   } mul_req_type;

   // (a + b) mod m for a, b below m
   function automatic word_type add_mod(input word_type a, input word_type b,
                                        input word_type m);
      logic [WORD_WIDTH:0] sum;
      logic [WORD_WIDTH:0] diff;
      begin
         sum  = {1'b0, a} + {1'b0, b};
         diff = sum - {1'b0, m};
         add_mod = (sum >= {1'b0, m}) ? diff[WORD_WIDTH-1:0] : sum[WORD_WIDTH-1:0];
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/mexp_ifs.sv */
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface mexp_req_if import mexp_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     opcode;
   word_type value;
   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mexp_rsp_if import mexp_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type result;
   logic     error;
   modport source (output valid, output result, output error, input ready);
   modport sink   (input valid, input result, input error, output ready);
endinterface
`default_nettype wire

/* rtl/mexp_modmul.sv */
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mexp_modmul import mexp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire word_type    modulus,
   input  wire mul_req_type req,
   output logic             done,
   output word_type         product
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   bit_idx_type cnt_ff, cnt_in;
   word_type    a_ff, a_in;
   word_type    b_ff, b_in;
   word_type    m_ff, m_in;
   word_type    acc_ff, acc_in;
   word_type    dbl;
   word_type    addend;

   // double, then add a when the current multiplier bit is set
   assign dbl    = add_mod(acc_ff, acc_ff, m_ff);
   assign addend = b_ff[WORD_WIDTH-1] ? a_ff : '0;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = BIT_LAST;
         a_in    = req.a;
         b_in    = req.b;
         m_in    = modulus;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = add_mod(dbl, addend, m_ff);
         b_in   = {b_ff[WORD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - bit_idx_type'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

/* rtl/modular_exponentiation_core.sv */
// Top level: register file, square-and-multiply sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// Modular exponentiation core. Each request beat carries an opcode and a 32-bit value;
// encrypt raises the value to the public exponent, decrypt to the private exponent,
// modulo the modulus register, with every product exact. One response beat follows each
// request. A zero modulus, or an encrypt value not below the modulus, returns result 0
// with error set; a zero exponent returns 1. Latency is set by the single bit-serial
// modular multiplier: one product reduces the value, then each of the WORD_WIDTH
// exponent bits costs a square plus a multiply when the bit is set, with one sequencer
// step per bit. Error and zero-exponent requests skip the multiplier and go straight
// to the finish state. The core takes one request at a time; req ready is high only
// while the sequencer is idle, and a finished result sits in the response register so a
// new request can start while it waits to be taken.
// Configuration registers must be written only while the core is idle.
module modular_exponentiation_core import mexp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   mexp_req_if.sink         req_chan,
   mexp_rsp_if.source       rsp_chan,
   input  wire logic        csr_we,
   input  wire csr_idx_type csr_index,
   input  wire word_type    csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SQR    = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;

   // configuration registers
   word_type modulus_ff, modulus_in;
   word_type pub_exp_ff, pub_exp_in;
   word_type priv_exp_ff, priv_exp_in;

   // sequencer
   logic [2:0]  state_ff, state_in;
   bit_idx_type bit_ff, bit_in;
   word_type    exp_ff, exp_in;
   word_type    acc_ff, acc_in;
   word_type    sq_ff, sq_in;
   logic        err_ff, err_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_result_ff, rsp_result_in;
   logic        rsp_error_ff, rsp_error_in;

   mul_req_type mul_req;
   logic        mul_done;
   word_type    mul_product;

   logic        accept;
   logic        slot_free;
   word_type    req_exp;
   logic        req_err;
   word_type    one_mod;

   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   // register writes; unused index is dropped
   always_comb begin
      modulus_in  = modulus_ff;
      pub_exp_in  = pub_exp_ff;
      priv_exp_in = priv_exp_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MODULUS:     modulus_in  = csr_wdata;
            REG_PUBLIC_EXP:  pub_exp_in  = csr_wdata;
            REG_PRIVATE_EXP: priv_exp_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_exp   = (req_chan.opcode == OP_DECRYPT) ? priv_exp_ff : pub_exp_ff;
   assign req_err   = (modulus_ff == '0) ||
                      ((req_chan.opcode == OP_ENCRYPT) && (req_chan.value >= modulus_ff));
   // 1 mod m; zero when the modulus is one
   assign one_mod   = (modulus_ff == word_type'(1)) ? '0 : word_type'(1);

   always_comb begin
      state_in      = state_ff;
      bit_in        = bit_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      err_in        = err_ff;
      mul_req.start = 1'b0;
      mul_req.a     = acc_ff;
      mul_req.b     = sq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in = req_exp;
               err_in = req_err;
               bit_in = '0;
               if (req_err) begin
                  acc_in   = '0;
                  state_in = ST_FIN;
               end else if (req_exp == '0) begin
                  acc_in   = word_type'(1);
                  state_in = ST_FIN;
               end else begin
                  // reduce the value first: (1 mod m) * value mod m
                  acc_in        = one_mod;
                  mul_req.start = 1'b1;
                  mul_req.a     = one_mod;
                  mul_req.b     = req_chan.value;
                  state_in      = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               sq_in    = mul_product;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            mul_req.start = 1'b1;
            if (exp_ff[bit_ff]) begin
               mul_req.a = acc_ff;
               mul_req.b = sq_ff;
               state_in  = ST_MUL;
            end else begin
               mul_req.a = sq_ff;
               mul_req.b = sq_ff;
               state_in  = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               acc_in        = mul_product;
               mul_req.start = 1'b1;
               mul_req.a     = sq_ff;
               mul_req.b     = sq_ff;
               state_in      = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               sq_in = mul_product;
               if (bit_ff == BIT_LAST) begin
                  state_in = ST_FIN;
               end else begin
                  bit_in   = bit_ff + bit_idx_type'(1);
                  state_in = ST_STEP;
               end
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               rsp_error_in  = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= '0;
         pub_exp_ff   <= '0;
         priv_exp_ff  <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         pub_exp_ff   <= pub_exp_in;
         priv_exp_ff  <= priv_exp_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_ff        <= bit_in;
      exp_ff        <= exp_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      err_ff        <= err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;
   assign rsp_chan.error  = rsp_error_ff;

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the modular exponentiation core: directed table, then random phases.
`timescale 1ns / 1ps
module tb import mexp_pkg::*; ();

   localparam int ROWS          = 37;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 31;
   localparam int HOLD_CYCLES   = 8000;     // long receiver hold, fills the core
   localparam int DRAIN_CYCLES  = 2500;     // worst-case exponentiation plus margin
   localparam int CYCLE_LIMIT   = 5000000;

   // index 3 decodes to no register; writes to it must be dropped
   localparam csr_idx_type REG_UNUSED = csr_idx_type'(3);

   typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;

   typedef struct packed {
      word_type result;
      logic     error;
   } result_beat_type;

   typedef struct {
      bit              is_write;
      csr_idx_type     idx;
      word_type        wdata;
      logic            opcode;
      word_type        value;
      bit              known;      // expected beat typed in below, else computed
      result_beat_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_idx_type csr_index;
   word_type    csr_wdata;

   mexp_req_if req_bus ();
   mexp_rsp_if rsp_bus ();

   modular_exponentiation_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the key registers
   word_type cfg_modulus  = '0;
   word_type cfg_pub_exp  = '0;
   word_type cfg_priv_exp = '0;

   result_beat_type modpow_owed [$];   // one entry per accepted request, oldest first
   int mismatches    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int rejected_seen = 0;
   int setups_run    = 0;
   int cycle_count   = 0;
   int rsp_stall_pct = 0;           // owned by the stimulus process, read by the receiver
   int hold_requests = 0;

   function automatic plan_row_type row_write(input csr_idx_type idx, input word_type data);
      plan_row_type r;
      r = '{1'b1, idx, data, OP_ENCRYPT, '0, 1'b0, '0};
      return r;
   endfunction

   function automatic plan_row_type row_known(input logic op, input word_type val,
                                              input word_type res, input logic err);
      plan_row_type r;
      r = '{1'b0, REG_MODULUS, '0, op, val, 1'b1, '{res, err}};
      return r;
   endfunction

   function automatic plan_row_type row_calc(input logic op, input word_type val);
      plan_row_type r;
      r = '{1'b0, REG_MODULUS, '0, op, val, 1'b0, '0};
      return r;
   endfunction

   // value ^ exponent mod modulus, products held at 64 bits so nothing overflows
   function automatic result_beat_type calc_modpow(input logic op, input word_type val);
      result_beat_type r;
      word_type        ex;
      logic [63:0]     acc;
      logic [63:0]     sq;
      logic [63:0]     m;
      int              i;
      ex = (op == OP_DECRYPT) ? cfg_priv_exp : cfg_pub_exp;
      m  = {32'd0, cfg_modulus};
      r  = '{'0, 1'b0};
      if (cfg_modulus == 0 || (op == OP_ENCRYPT && val >= cfg_modulus)) begin
         r.error = 1'b1;
      end else if (ex == 0) begin
         r.result = word_type'(1);
      end else begin
         acc = 64'd1 % m;
         sq  = {32'd0, val} % m;
         for (i = 0; i < WORD_WIDTH; i++) begin
            if (ex[i]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
         end
         r.result = acc[WORD_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic word_type pick_exponent();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return word_type'(1);
         3, 4:    return word_type'($urandom_range(255, 2));
         default: return word_type'($urandom());
      endcase
   endfunction

   // Directed table. Typed-in beats: reset state, the textbook 3233 key pair,
   // rejections, zero exponent, modulus one, and exponent one.
   plan_row_type plan [ROWS] = '{
      row_known(OP_ENCRYPT, 32'd0, 32'd0, 1'b1),            // zero modulus after reset
      row_known(OP_DECRYPT, 32'hFFFF_FFFF, 32'd0, 1'b1),    // zero modulus, decrypt too
      row_write(REG_MODULUS, 32'd3233),
      row_write(REG_PUBLIC_EXP, 32'd17),
      row_write(REG_PRIVATE_EXP, 32'd2753),
      row_write(REG_UNUSED, 32'd0),                          // must not clobber anything
      row_known(OP_ENCRYPT, 32'd65, 32'd2790, 1'b0),
      row_known(OP_DECRYPT, 32'd2790, 32'd65, 1'b0),
      row_known(OP_ENCRYPT, 32'd3233, 32'd0, 1'b1),         // value equal to modulus
      row_known(OP_ENCRYPT, 32'hFFFF_FFFF, 32'd0, 1'b1),
      row_calc (OP_DECRYPT, 32'hFFFF_FFFF),                  // decrypt reduces first
      row_known(OP_ENCRYPT, 32'd0, 32'd0, 1'b0),
      row_known(OP_ENCRYPT, 32'd3232, 32'd3232, 1'b0),      // (-1)^odd
      row_write(REG_PUBLIC_EXP, 32'd0),
      row_known(OP_ENCRYPT, 32'd5, 32'd1, 1'b0),            // zero exponent
      row_calc (OP_DECRYPT, 32'd3000),
      row_write(REG_MODULUS, 32'd1),
      row_known(OP_ENCRYPT, 32'd0, 32'd1, 1'b0),            // zero exponent wins over mod 1
      row_known(OP_DECRYPT, 32'd7, 32'd0, 1'b0),
      row_known(OP_ENCRYPT, 32'd1, 32'd0, 1'b1),
      row_write(REG_MODULUS, 32'hFFFF_FFFF),
      row_write(REG_PUBLIC_EXP, 32'hFFFF_FFFF),
      row_write(REG_PRIVATE_EXP, 32'd1),
      row_calc (OP_ENCRYPT, 32'hFFFF_FFFE),
      row_known(OP_ENCRYPT, 32'hFFFF_FFFF, 32'd0, 1'b1),
      row_known(OP_DECRYPT, 32'hFFFF_FFFF, 32'd0, 1'b0),
      row_known(OP_DECRYPT, 32'h1234_5678, 32'h1234_5678, 1'b0),
      row_known(OP_ENCRYPT, 32'd0, 32'd0, 1'b0),
      row_write(REG_PRIVATE_EXP, 32'hFFFF_FFFF),
      row_calc (OP_DECRYPT, 32'hFFFF_FFFE),
      row_calc (OP_DECRYPT, 32'h8000_0000),
      row_write(REG_MODULUS, 32'hFFF1_FFF1),                 // 65521 * 65537
      row_write(REG_PUBLIC_EXP, 32'd65537),
      row_calc (OP_ENCRYPT, 32'hDEAD_BEEF),
      row_calc (OP_DECRYPT, 32'hFFFF_FFFF),
      row_calc (OP_ENCRYPT, 32'hA5A5_A5A5),
      row_known(OP_ENCRYPT, 32'hFFF2_0000, 32'd0, 1'b1)
   };

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // Offer one request beat and hold it until taken. Valid stays high on return
   // so back-to-back beats never drop it.
   task automatic send_item(input logic op, input word_type val, input bit known,
                            input result_beat_type want);
      result_beat_type due;
      due = known ? want : calc_modpow(op, val);
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.value  <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      modpow_owed.push_back(due);
      items_sent++;
   endtask

   // Key registers may only change with nothing in flight.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (modpow_owed.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input word_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_MODULUS:     cfg_modulus  = data;
         REG_PUBLIC_EXP:  cfg_pub_exp  = data;
         REG_PRIVATE_EXP: cfg_priv_exp = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Response side: random stalls, rare bursts, and the long hold on request.
   initial begin : rsp_side
      int burst;
      int holds_done;
      burst      = 0;
      holds_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            burst      = HOLD_CYCLES;
         end else if (rsp_stall_pct != 0 && burst == 0 && $urandom_range(19999) == 0) begin
            burst = $urandom_range(3000, 1);
         end
         if (burst != 0) begin
            burst--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare every response beat with the oldest owed result.
   always @(posedge clock) begin : check_results
      result_beat_type due;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (modpow_owed.size() == 0) begin
            report_mismatch($sformatf("result beat %h err %b with nothing owed",
                                      rsp_bus.result, rsp_bus.error));
         end else begin
            due = modpow_owed.pop_front();
            if (rsp_bus.result !== due.result)
               report_mismatch($sformatf("result %h, want %h", rsp_bus.result, due.result));
            if (rsp_bus.error !== due.error)
               report_mismatch($sformatf("error %b, want %b", rsp_bus.error, due.error));
            if (due.error) rejected_seen++;
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results still owed",
                  cycle_count, modpow_owed.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      int        k;
      int        ph;
      int        n;
      int        gap;
      int        send_idle_pct;
      pace_type  pace;
      logic      op;
      word_type  val;
      word_type  m;

      send_idle_pct = 0;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= OP_ENCRYPT;
      req_bus.value  <= '0;
      csr_we         <= 1'b0;
      csr_index      <= REG_MODULUS;
      csr_wdata      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling on either side
      for (k = 0; k < ROWS; k++) begin
         if (plan[k].is_write) begin
            wait_idle();
            write_reg(plan[k].idx, plan[k].wdata);
         end else begin
            send_item(plan[k].opcode, plan[k].value, plan[k].known, plan[k].want);
         end
      end

      // random key setups, each under one pacing mode
      for (ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         pace = pace_type'(ph % 4);
         case (pace)
            PACE_FREE:       begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 60; rsp_stall_pct <= 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  rsp_stall_pct <= 60; end
            PACE_BOTH:       begin send_idle_pct = 25; rsp_stall_pct <= 25; end
         endcase

         case ($urandom_range(9))
            0:       m = word_type'(1);
            1:       m = '1;
            2, 3:    m = word_type'($urandom_range(65535, 2));
            4:       m = {1'b1, 31'($urandom())};
            default: m = word_type'($urandom());
         endcase
         write_reg(REG_MODULUS, m);
         write_reg(REG_PUBLIC_EXP, pick_exponent());
         write_reg(REG_PRIVATE_EXP, pick_exponent());
         setups_run++;

         // receiver holds off while requests keep coming: core fills, req ready drops
         if (ph == 4) hold_requests <= hold_requests + 1;

         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (send_idle_pct != 0) begin
               gap = 0;
               // mostly short gaps; now and then land mid-computation
               if ($urandom_range(7) == 0) gap = $urandom_range(2500, 1);
               else while ($urandom_range(99) < send_idle_pct) gap++;
               if (gap != 0) begin
                  req_bus.valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            op = $urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT;
            // most values below the modulus; the rest span the full word
            if (cfg_modulus != 0 && $urandom_range(4) != 0)
               val = word_type'($urandom_range(cfg_modulus - 1, 0));
            else
               val = word_type'($urandom());
            send_item(op, val, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (modpow_owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests, %0d results checked (%0d rejected), over %0d random key setups",
               items_sent, results_seen, rejected_seen, setups_run);
      $display("plus the directed table, with free, sender-idle, stall, mixed and long-hold pacing");
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
